// ===== design/scld_pkg.sv =====
// Package for the serial command line decoder.
// Holds command codes, state machine encoding, sizes and character helpers.
// No dependencies.
package scld_pkg;

  localparam int LINE_DEPTH_DEF      = 32;
  localparam int FRACTION_DIGITS_DEF = 9;

  typedef enum logic [3:0] {
    CMD_OFF      = 4'd0,
    CMD_MANUAL   = 4'd1,
    CMD_PID      = 4'd2,
    CMD_SET_KP   = 4'd3,
    CMD_SET_KI   = 4'd4,
    CMD_SET_KD   = 4'd5,
    CMD_SHOW_PID = 4'd6,
    CMD_HELP     = 4'd7,
    CMD_RESET    = 4'd8,
    CMD_SAMPLE   = 4'd9,
    CMD_ERROR    = 4'd10
  } cmd_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,    // taking bytes
    ST_RD,      // memory read in flight
    ST_W1,      // scanning the first word
    ST_W2,      // scanning the second word
    ST_SKIP,    // skipping one byte after a word
    ST_INT,     // accumulating the integer part
    ST_FRAC,    // accumulating fraction digits
    ST_MUL,     // fraction times 65536 plus half scale
    ST_DIV,     // restoring division by the scale
    ST_DONE,    // result assembly
    ST_OUT      // result waits for the receiver
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_scan;   // start a scan at address zero
    logic rd_next;    // advance read position
    logic w1_step;    // fold current byte into word one match
    logic w2_step;    // fold current byte into word two match
    logic int_step;   // fold digit into integer accumulators
    logic frac_step;  // fold digit into fraction accumulator
    logic mul_go;     // form the dividend
    logic div_step;   // one quotient bit
    logic done;       // assemble result
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cur_letter;
    logic cur_digit;
    logic cur_dot;
    logic past_end;
    logic [2:0] top_word;   // matched first word; top_none flags no match
    logic top_none;
    logic div_last;
  } dp_stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c == 8'h0D || c == 8'h0A;
  endfunction

  // Keyword character j of top word w, zero past its end.
  function automatic logic [7:0] top_char(input logic [2:0] w, input logic [2:0] j);
    logic [47:0] s;
    unique case (w)
      3'd0: s = {"off", 24'h0};
      3'd1: s = "manual";
      3'd2: s = {"pid", 24'h0};
      3'd3: s = {"set", 24'h0};
      3'd4: s = {"show", 16'h0};
      3'd5: s = {"help", 16'h0};
      3'd6: s = {"reset", 8'h0};
      default: s = "sample";
    endcase
    return (j > 3'd5) ? 8'h00 : s[47 - 8*j -: 8];
  endfunction

  function automatic logic [7:0] gain_char(input logic [1:0] w, input logic [2:0] j);
    logic [23:0] s;
    unique case (w)
      2'd0: s = "kp";
      2'd1: s = "ki";
      2'd2: s = "kd";
      default: s = "pid";
    endcase
    s = (w == 2'd3) ? s : {s[15:0], 8'h0};
    return (j > 3'd2) ? 8'h00 : s[23 - 8*j -: 8];
  endfunction

endpackage

// ===== design/scld_ram.sv =====
// Generic simple dual port RAM (one write port, one read port) with registered read.
// No dependencies.
module scld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/scld_datapath.sv =====
// Datapath of the serial command line decoder: line store, match flags,
// decimal accumulators and the fraction divider. Uses scld_pkg and scld_ram.
module scld_datapath #(
  parameter int LINE_DEPTH      = scld_pkg::LINE_DEPTH_DEF,
  parameter int FRACTION_DIGITS = scld_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_beat,
  input  logic [7:0]                    in_rx_byte,
  input  scld_pkg::dp_cmd_t             cmd,
  output scld_pkg::dp_stat_t            stat,
  output logic                          line_hit,
  output logic [3:0]                    res_command,
  output logic [31:0]                   res_int,
  output logic [31:0]                   res_fixed
);
  import scld_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int PW = $clog2(LINE_DEPTH + 2);

  logic [CW-1:0] fill_r, fill_nxt;
  logic [7:0]    prev_r;
  logic [CW-1:0] len_r;
  logic [PW-1:0] pos_r;
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic [7:0]    cur;
  logic          hit;

  scld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_ram (
    .clk(clk), .we(in_beat), .waddr(fill_r[AW-1:0]), .wdata(in_rx_byte),
    .raddr(raddr), .rdata(rdata)
  );

  // Terminator needs two bytes; prev_r is only meaningful when fill_r >= 1.
  assign hit = in_beat && fill_r != '0 && is_term(in_rx_byte) && is_term(prev_r);
  assign line_hit = hit;

  always_comb begin
    fill_nxt = fill_r + CW'(1);
    if (hit || fill_nxt >= CW'(LINE_DEPTH - 1)) fill_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else if (in_beat) fill_r <= fill_nxt;
    if (in_beat) prev_r <= in_rx_byte;
    if (hit) len_r <= fill_r + CW'(1);
  end

  // Read address runs one ahead so data arrives as the position advances.
  logic [PW-1:0] pos_ahead;
  assign pos_ahead = cmd.clr_scan ? '0 : (cmd.rd_next ? pos_r + PW'(1) : pos_r);
  assign raddr = pos_ahead[AW-1:0];
  assign cur = (PW'(pos_r) < PW'(len_r)) ? rdata : 8'h00;

  always_ff @(posedge clk) begin
    pos_r <= pos_ahead;
  end

  // Word match: per keyword, still-matching flag and index into the keyword.
  logic [7:0] t_ok_r;
  logic [3:0] g_ok_r;
  logic [2:0] wi_r;
  logic       w1_any_r, w2_any_r;
  always_ff @(posedge clk) begin
    if (cmd.clr_scan) begin
      t_ok_r <= '1; g_ok_r <= '1; wi_r <= '0; w1_any_r <= 1'b0; w2_any_r <= 1'b0;
    end else if (cmd.w1_step) begin
      for (int k = 0; k < 8; k++)
        if (top_char(3'(k), wi_r) != 8'h00 && top_char(3'(k), wi_r) != cur)
          t_ok_r[k] <= 1'b0;
      wi_r <= (wi_r == 3'd7) ? wi_r : wi_r + 3'd1;
      w1_any_r <= 1'b1;
    end else if (cmd.w2_step) begin
      for (int k = 0; k < 4; k++)
        if (gain_char(2'(k), wi_r) != 8'h00 && gain_char(2'(k), wi_r) != cur)
          g_ok_r[k] <= 1'b0;
      wi_r <= (wi_r == 3'd7) ? wi_r : wi_r + 3'd1;
      w2_any_r <= 1'b1;
    end else if (cmd.rd_next) begin
      wi_r <= '0;
    end
  end

  logic [2:0] top_w;
  logic       top_none;
  always_comb begin
    top_w = '0; top_none = 1'b1;
    for (int k = 7; k >= 0; k--)
      if (t_ok_r[k] && w1_any_r) begin top_w = 3'(k); top_none = 1'b0; end
  end

  // Decimal accumulators.
  logic [31:0] int_r;
  logic [16:0] ip_r;
  logic [29:0] frac_r, scale_r;
  logic [3:0]  k_r;
  logic [35:0] int_t;
  logic [20:0] ip_t;
  always_comb begin
    int_t = {4'b0, int_r} * 36'd10 + 36'(cur - 8'h30);
    ip_t  = {4'b0, ip_r} * 21'd10 + 21'(cur - 8'h30);
  end

  // Divider: (frac*65536 + scale/2) / scale, 47 bit dividend.
  localparam int DW = 47;
  logic [DW-1:0] dvd_r;
  logic [30:0]   rem_r;
  logic [5:0]    dcnt_r;
  logic [30:0]   rem_sh;
  assign rem_sh = {rem_r[29:0], dvd_r[DW-1]};

  always_ff @(posedge clk) begin
    if (cmd.clr_scan) begin
      int_r <= '0; ip_r <= '0; frac_r <= '0; scale_r <= 30'd1; k_r <= '0;
    end else if (cmd.int_step) begin
      int_r <= int_t[31:0];
      ip_r  <= (ip_t > 21'd65535) ? 17'd65536 : ip_t[16:0];
    end else if (cmd.frac_step) begin
      if (k_r < 4'(FRACTION_DIGITS)) begin
        frac_r  <= 30'(frac_r * 30'd10 + 30'(cur - 8'h30));
        scale_r <= 30'(scale_r * 30'd10);
        k_r     <= k_r + 4'd1;
      end
    end
    if (cmd.mul_go) begin
      dvd_r  <= DW'({frac_r, 16'h0}) + DW'(scale_r >> 1);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= 31'(scale_r)) begin
        rem_r <= rem_sh - 31'(scale_r);
        dvd_r <= {dvd_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 6'd1;
    end
  end

  // Result assembly.
  logic [32:0] tot;
  logic [31:0] fv;
  assign tot = {ip_r[15:0], 16'h0} + 33'(dvd_r);
  assign fv  = (ip_r[16] || tot[32]) ? 32'hFFFF_FFFF : tot[31:0];

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      res_int   <= '0;
      res_fixed <= '0;
      res_command <= CMD_ERROR;
      if (!top_none) begin
        unique case (top_w)
          3'd0: res_command <= CMD_OFF;
          3'd1: begin res_command <= CMD_MANUAL; res_int <= int_r; end
          3'd2: res_command <= CMD_PID;
          3'd3: begin
            if (w2_any_r && g_ok_r[0]) begin res_command <= CMD_SET_KP; res_fixed <= fv; end
            else if (w2_any_r && g_ok_r[1]) begin
              res_command <= CMD_SET_KI; res_fixed <= fv;
            end else if (w2_any_r && g_ok_r[2]) begin
              res_command <= CMD_SET_KD; res_fixed <= fv;
            end
          end
          3'd4: if (w2_any_r && g_ok_r[3]) res_command <= CMD_SHOW_PID;
          3'd5: res_command <= CMD_HELP;
          3'd6: res_command <= CMD_RESET;
          default: begin res_command <= CMD_SAMPLE; res_fixed <= fv; end
        endcase
      end
    end
  end

  assign stat.cur_letter = is_letter(cur);
  assign stat.cur_digit  = is_digit(cur);
  assign stat.cur_dot    = cur == 8'h2E;
  assign stat.past_end   = PW'(pos_r) >= PW'(len_r);
  assign stat.top_word   = top_w;
  assign stat.top_none   = top_none;
  assign stat.div_last   = dcnt_r == 6'(DW - 1);
endmodule

// ===== design/scld_ctrl.sv =====
// Controller state machine of the serial command line decoder.
// Uses scld_pkg; drives scld_datapath through dp_cmd_t.
module scld_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               line_hit,
  input  scld_pkg::dp_stat_t stat,
  output scld_pkg::dp_cmd_t  cmd,
  output logic               out_valid,
  input  logic               out_ready
);
  import scld_pkg::*;

  state_t st_r, st_nxt;
  logic   skip_to_w2_r, skip_to_w2_nxt; // where a skip leads

  // Number route: after word one the decoded keyword picks the argument type.
  logic [2:0] w;
  assign w = stat.top_word;

  always_comb begin
    st_nxt = st_r;
    skip_to_w2_nxt = skip_to_w2_r;
    unique case (st_r)
      ST_IDLE: if (in_valid && line_hit) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_W1;
      ST_W1: begin
        if (!stat.cur_letter || stat.past_end) begin
          if (stat.top_none) st_nxt = ST_DONE;
          else if (w == 3'd3 || w == 3'd4) begin
            st_nxt = ST_SKIP; skip_to_w2_nxt = 1'b1;
          end else if (w == 3'd1 || w == 3'd7) begin
            st_nxt = ST_SKIP; skip_to_w2_nxt = 1'b0;
          end else st_nxt = ST_DONE;
        end
      end
      ST_SKIP: st_nxt = skip_to_w2_r ? ST_W2 : ST_INT;
      ST_W2: if (!stat.cur_letter || stat.past_end) begin
        if (w == 3'd4) st_nxt = ST_DONE;
        else begin st_nxt = ST_SKIP; skip_to_w2_nxt = 1'b0; end
      end
      ST_INT: if (!stat.cur_digit || stat.past_end) begin
        if (w != 3'd1 && stat.cur_dot) st_nxt = ST_FRAC;
        else st_nxt = (w == 3'd1) ? ST_DONE : ST_MUL;
      end
      ST_FRAC: if (!stat.cur_digit || stat.past_end) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_DIV;
      ST_DIV:  if (stat.div_last) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin in_ready = 1'b1; cmd.clr_scan = 1'b1; end
      ST_W1: if (stat.cur_letter && !stat.past_end) begin
        cmd.w1_step = 1'b1; cmd.rd_next = 1'b1;
      end
      ST_SKIP: cmd.rd_next = 1'b1;
      ST_W2: if (stat.cur_letter && !stat.past_end) begin
        cmd.w2_step = 1'b1; cmd.rd_next = 1'b1;
      end
      ST_INT: begin
        if (stat.cur_digit && !stat.past_end) begin cmd.int_step = 1'b1; cmd.rd_next = 1'b1; end
        else if (w != 3'd1 && stat.cur_dot) cmd.rd_next = 1'b1;
      end
      ST_FRAC: if (stat.cur_digit && !stat.past_end) begin
        cmd.frac_step = 1'b1; cmd.rd_next = 1'b1;
      end
      ST_MUL:  cmd.mul_go = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.done = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; skip_to_w2_r <= 1'b0;
    end else begin
      st_r <= st_nxt; skip_to_w2_r <= skip_to_w2_nxt;
    end
  end

  // A result is shown only after assembly.
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.done)) else $error("out_valid without assembly");
  // No input is taken while a result waits.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input accepted during output");
  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

// ===== design/serial_command_line_decoder_unit.sv =====
// Top level of the serial command line decoder.
// Instantiates scld_ctrl and scld_datapath; uses scld_pkg.
//
// Usage: received characters enter one beat at a time on in_valid/in_ready
// with in_rx_byte. Each byte is written to the line store as it is taken.
// When the last two bytes of a line are CR or LF, the controller walks the
// stored line one byte a cycle through the memory read port, matches the
// first and second words and accumulates the decimal argument. Only set and
// sample then run a restoring divider for the fraction rounding.
// One result beat then appears on out_valid/out_ready with out_command,
// out_int_arg, out_fixed_arg. After a terminating byte the controller does
// a memory read, a step per scanned byte, a step at the end of each word
// or number, then assembly; set and sample also form the dividend and run
// the divider before assembly.
// While the result waits for out_ready, in_ready stays low, so a stalled
// receiver holds back input. Reset empties the line and returns to taking
// bytes; the line store itself needs no clearing since only written entries
// are read. A line reaching LINE_DEPTH-1 bytes without terminator is dropped.
module serial_command_line_decoder_unit #(
  parameter int LINE_DEPTH      = scld_pkg::LINE_DEPTH_DEF,
  parameter int FRACTION_DIGITS = scld_pkg::FRACTION_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_command,
  output logic [31:0] out_int_arg,
  output logic [31:0] out_fixed_arg
);
  import scld_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       line_hit;

  scld_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .line_hit(line_hit), .stat(stat), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready)
  );

  scld_datapath #(.LINE_DEPTH(LINE_DEPTH), .FRACTION_DIGITS(FRACTION_DIGITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_beat(in_valid && in_ready),
    .in_rx_byte(in_rx_byte), .cmd(cmd), .stat(stat),
    .line_hit(line_hit), .res_command(out_command), .res_int(out_int_arg),
    .res_fixed(out_fixed_arg)
  );
endmodule

// ===== tb/sv/scld_checker.sv =====
// Checker for the serial command line decoder: watches both channels,
// predicts each decoded command from the accepted bytes and compares results.
// Depends on scld_pkg for the command codes.
module scld_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_command,
  input  logic [31:0] out_int_arg,
  input  logic [31:0] out_fixed_arg,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import scld_pkg::*;

  localparam int DEPTH = LINE_DEPTH_DEF;
  localparam int FRAC_MAX = FRACTION_DIGITS_DEF;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] int_arg;
    logic [31:0] fixed_arg;
  } decoded_t;

  logic [7:0] line_copy [DEPTH];
  int         line_len;
  decoded_t   pending_cmds [$];

  function automatic logic [7:0] char_at(int i);
    return (i < line_len) ? line_copy[i] : 8'h00;
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int end_of_word(int pos);
    while (pos < line_len && letter_char(char_at(pos))) pos++;
    return pos;
  endfunction

  // Prefix match in either direction; an empty word never matches.
  function automatic bit word_is(int start, int stop, string kw);
    int i;
    i = 0;
    if (stop <= start) return 0;
    while (start + i < stop && i < kw.len()) begin
      if (char_at(start + i) != kw[i]) return 0;
      i++;
    end
    return 1;
  endfunction

  function automatic logic [31:0] integer_value(int pos);
    logic [31:0] acc;
    acc = 0;
    while (pos < line_len && digit_char(char_at(pos))) begin
      acc = acc * 10 + (char_at(pos) - "0");
      pos++;
    end
    return acc;
  endfunction

  // Unsigned Q16.16 with rounding half up and saturation.
  function automatic logic [31:0] fixed_value(int pos);
    longint unsigned ip, frac, scale, total;
    int k;
    ip = 0; frac = 0; scale = 1; k = 0;
    while (pos < line_len && digit_char(char_at(pos))) begin
      ip = ip * 10 + (char_at(pos) - "0");
      if (ip > 65535) ip = 65536;
      pos++;
    end
    if (char_at(pos) == ".") begin
      pos++;
      while (pos < line_len && digit_char(char_at(pos))) begin
        if (k < FRAC_MAX) begin
          frac = frac * 10 + (char_at(pos) - "0");
          scale *= 10;
          k++;
        end
        pos++;
      end
    end
    if (ip > 65535) return 32'hFFFF_FFFF;
    total = ip * 65536 + (frac * 65536 + scale / 2) / scale;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic decoded_t decode_command();
    decoded_t r;
    string tops [8];
    string gains [3];
    int e1, p, e2, w;
    tops = '{"off", "manual", "pid", "set", "show", "help", "reset", "sample"};
    gains = '{"kp", "ki", "kd"};
    r.command = CMD_ERROR; r.int_arg = 0; r.fixed_arg = 0;
    e1 = end_of_word(0);
    p = e1 + 1;
    w = 8;
    for (int j = 7; j >= 0; j--) if (word_is(0, e1, tops[j])) w = j;
    case (w)
      0: r.command = CMD_OFF;
      1: begin
        r.command = CMD_MANUAL;
        r.int_arg = integer_value(p);
      end
      2: r.command = CMD_PID;
      3: begin
        e2 = end_of_word(p);
        for (int j = 2; j >= 0; j--)
          if (word_is(p, e2, gains[j])) begin
            r.command = cmd_t'(CMD_SET_KP + j);
            r.fixed_arg = fixed_value(e2 + 1);
          end
      end
      4: begin
        e2 = end_of_word(p);
        if (word_is(p, e2, "pid")) r.command = CMD_SHOW_PID;
      end
      5: r.command = CMD_HELP;
      6: r.command = CMD_RESET;
      7: begin
        r.command = CMD_SAMPLE;
        r.fixed_arg = fixed_value(p);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit line_end_char(logic [7:0] c);
    return c == 8'h0D || c == 8'h0A;
  endfunction

  assign pending_count = pending_cmds.size();

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      line_len = 0;
      fail_count <= 0;
      result_count <= 0;
      pending_cmds.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (line_len >= DEPTH) line_len = 0;
        line_copy[line_len] = in_rx_byte;
        line_len++;
        if (line_len >= 2 && line_end_char(line_copy[line_len - 1]) &&
            line_end_char(line_copy[line_len - 2])) begin
          pending_cmds.push_back(decode_command());
          line_len = 0;
        end
        if (line_len >= DEPTH - 1) line_len = 0;
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (pending_cmds.size() == 0) begin
          $display("%0t: unexpected result cmd=%0d int=%h fixed=%h", $time,
                   out_command, out_int_arg, out_fixed_arg);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_cmds.pop_front();
          if (out_command != want.command || out_int_arg != want.int_arg ||
              out_fixed_arg != want.fixed_arg) begin
            $display("%0t: mismatch expected cmd=%0d int=%h fixed=%h, got cmd=%0d int=%h fixed=%h",
                     $time, want.command, want.int_arg, want.fixed_arg,
                     out_command, out_int_arg, out_fixed_arg);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the serial command line decoder testbench: clock, reset, byte
// stimulus and result back-pressure. Uses scld_checker and scld_pkg.
module tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_command;
  logic [31:0] out_int_arg;
  logic [31:0] out_fixed_arg;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          cycle_count;
  int          bytes_sent;
  bit          hold_receiver;

  localparam int CYCLE_LIMIT = 900000;

  serial_command_line_decoder_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_command(out_command),
    .out_int_arg(out_int_arg), .out_fixed_arg(out_fixed_arg)
  );

  scld_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_command(out_command),
    .out_int_arg(out_int_arg), .out_fixed_arg(out_fixed_arg),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one byte beat at a falling edge and holds it steady until the
  // block takes it; returns at the accepting rising edge.
  task automatic send_byte(input logic [7:0] b);
    int g;
    g = gap_cycles();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Drops valid after the last offered beat.
  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string random_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  function automatic string line_ending();
    string e [4];
    e = '{"\r\n", "\n\n", "\r\r", "\n\r"};
    return e[$urandom_range(0, 3)];
  endfunction

  // A well-formed command with random keyword prefixes, arguments and
  // separators; the line is kept short enough not to be dropped.
  function automatic string random_command();
    string tops [8];
    string gains [4];
    string s, kw, sep;
    int w;
    tops = '{"off", "manual", "pid", "set", "show", "help", "reset", "sample"};
    gains = '{"kp", "ki", "kd", "pid"};
    w = $urandom_range(0, 7);
    kw = tops[w];
    s = ($urandom_range(0, 3) == 0) ? kw.substr(0, $urandom_range(0, kw.len() - 1)) : kw;
    sep = ($urandom_range(0, 4) == 0) ? string'(8'($urandom_range(0, 255))) : " ";
    if (w == 3 || w == 4) begin
      kw = gains[$urandom_range(0, 3)];
      s = {s, sep, kw.substr(0, $urandom_range(0, kw.len() - 1)), " "};
    end else s = {s, sep};
    if ($urandom_range(0, 5) != 0) s = {s, random_digits($urandom_range(0, 6))};
    if ($urandom_range(0, 2) != 0) s = {s, ".", random_digits($urandom_range(0, 11))};
    if (s.len() > 27) s = s.substr(0, 26);
    return s;
  endfunction

  // Receiver: random stalls, plus one long hold-off forced by the sender.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_receiver = 0;
      end else if ($urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap_cycles()) @(negedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    string junk;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    bytes_sent = 0;
    hold_receiver = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every command, argument extremes, and the odd lines.
    send_text("\n");                      // joins the next byte as a terminator pair
    send_text("\r\n");
    send_text("off\r\n");
    send_text("manual 4294967296\n\n");   // integer wraps
    send_text("pid\r\r");
    send_text("set kp 65535.99999999999\r\n");
    send_text("set ki 65536.5\n\r");
    send_text("set kd 0.000007629\r\n");
    send_text("show pid\r\n");
    send_text("show kp\r\n");
    send_text("help\r\n");
    send_text("reset\r\n");
    send_text("sample 1.5\r\n");
    send_text("s\r\n");                   // prefix takes the first keyword
    send_text("offset\r\n");
    send_text("OFF\r\n");
    send_text("9\r\n");
    send_text("abcdefghijklmnopqrstuvwxyzABCDE"); // dropped when full
    send_text("xyz\xff\x80\x7f\r\n");
    stop_sending();

    // The sender waits here until every pending result is back.
    while (pending_count != 0) @(negedge clk);

    // Long receiver hold-off while bytes keep coming.
    hold_receiver = 1;
    for (int i = 0; i < 6; i++) send_text("help\r\n");

    while (bytes_sent < 1180) begin
      if ($urandom_range(0, 9) < 8) begin
        send_text({random_command(), line_ending()});
      end else begin
        junk = "";
        repeat ($urandom_range(1, 40)) junk = {junk, string'(8'($urandom_range(0, 255)))};
        send_text(junk);
      end
    end
    stop_sending();

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d bytes covering all commands, argument extremes, junk and stalls.",
             bytes_sent);
    $display("Checked %0d decoded results.", result_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
